// ===== src/jls_pkg.sv =====
// Package: constants and types for the Jacobi linear solver.
`default_nettype none
package jls_pkg;
	localparam int MAX_UNKNOWNS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam logic [1:0] REG_EPSILON = 2'd0;
	localparam logic [1:0] REG_MAX_ITER = 2'd1;
	localparam logic [1:0] REG_SIZE = 2'd2;

	typedef enum logic [3:0] {
		ST_LOAD, ST_DOM_RD, ST_DOM_ACC, ST_DOM_END, ST_SW_START, ST_ACC_RD, ST_ACC_MUL,
		ST_ACC_ADD, ST_DIV, ST_DIV_END, ST_SW_END, ST_EMIT, ST_EMIT_WAIT
	} state_t;
endpackage
`default_nettype wire

// ===== src/jls_if.sv =====
// Valid/ready channel interfaces for input words and result words.
`default_nettype none
interface jls_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  row;
	logic [4:0]  col;
	logic signed [31:0] value;
	logic        last_element;
	modport source (output valid, row, col, value, last_element, input ready);
	modport sink (input valid, row, col, value, last_element, output ready);
endinterface

interface jls_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic signed [31:0] solution;
	logic [15:0] sweeps_done;
	logic        converged;
	logic        diag_dominant;
	logic        zero_pivot;
	logic        last_result;
	modport source (output valid, index, solution, sweeps_done, converged, diag_dominant,
		zero_pivot, last_result, input ready);
	modport sink (input valid, index, solution, sweeps_done, converged, diag_dominant,
		zero_pivot, last_result, output ready);
endinterface
`default_nettype wire

// ===== src/jls_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module jls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/jacobi_linear_solver.sv =====
// Jacobi linear solver: coefficient load, dominance check, sweeps, result emission.
// Load: one coefficient word per cycle; input stalls from the last word until all results leave.
// Solve: a dominance pass, clearing of the estimates, then per sweep: read, multiply and add per
// term and for b, the 64-step divider, one write per row, and compare/copy per entry.
// Emit: n result words, each held until the sink is ready.
// Reset (arst_n low) returns control to load and registers to 66/1000/16.
`default_nettype none
module jacobi_linear_solver import jls_pkg::*; #(
	parameter int MAX_UNKNOWNS = MAX_UNKNOWNS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	jls_in_if.sink           in_ch,
	jls_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	localparam int COLS = MAX_UNKNOWNS + 1;
	localparam int DEPTH = MAX_UNKNOWNS * COLS;
	localparam int AW = $clog2(DEPTH);
	localparam int IW = $clog2(MAX_UNKNOWNS);
	localparam int NW = $clog2(MAX_UNKNOWNS + 1);
	localparam int DIV_STEPS = 64;
	localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ACC_MIN = -ACC_MAX;

	// configuration registers
	logic [30:0] eps_q;
	logic [15:0] maxit_q;
	logic [4:0]  size_q;
	logic        cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 31'd66;
			maxit_q <= 16'd1000;
			size_q <= 5'd16;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_EPSILON:  eps_q <= pwdata[30:0];
				REG_MAX_ITER: maxit_q <= pwdata[15:0];
				REG_SIZE:     size_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[3:2])
			REG_EPSILON:  prdata = {1'b0, eps_q};
			REG_MAX_ITER: prdata = {16'd0, maxit_q};
			REG_SIZE:     prdata = {27'd0, size_q};
			default:      prdata = 32'd0;
		endcase
	end

	// active size n, clamped to 1..MAX_UNKNOWNS
	logic [NW-1:0] n_w;
	always_comb begin
		if (size_q == 5'd0) n_w = NW'(1);
		else if (32'(size_q) > MAX_UNKNOWNS) n_w = NW'(MAX_UNKNOWNS);
		else n_w = NW'(size_q);
	end

	state_t state_q, state_d;
	logic [IW-1:0] i_q;
	logic [NW-1:0] j_q, n_q;
	logic [15:0] sweep_q;
	logic conv_q, dom_q, zp_q, stop_q;
	logic signed [63:0] acc_q, prod_s2;
	logic signed [31:0] b_q, d_q;
	logic [63:0] off_q;
	logic [6:0] dstep_q;
	logic [63:0] dnum_q, dquo_q, drem_q;
	logic [31:0] dden_q;
	logic dneg_q;

	// coefficient RAM
	logic in_acc, in_ok;
	logic [AW-1:0] caddr;
	logic [31:0] crd;
	assign in_ok = (32'(in_ch.row) < MAX_UNKNOWNS) && (32'(in_ch.col) <= MAX_UNKNOWNS);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_LOAD);
	assign caddr = AW'(32'(i_q) * COLS + 32'(j_q));
	jls_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_coef (
		.clk(clk), .we(in_acc && in_ok),
		.waddr(AW'(32'(in_ch.row) * COLS + 32'(in_ch.col))),
		.wdata(in_ch.value), .raddr(caddr), .rdata(crd));

	// estimate RAMs: previous and current
	logic [IW-1:0] prd_a, cwr_a, crd_a;
	logic [31:0] prd, crd_e, cur_wdata, prev_wdata;
	logic cur_we, prev_we;
	logic [IW-1:0] cnt_q;
	jls_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS)) u_prev (
		.clk(clk), .we(prev_we), .waddr(cnt_q), .wdata(prev_wdata),
		.raddr(prd_a), .rdata(prd));
	jls_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS)) u_cur (
		.clk(clk), .we(cur_we), .waddr(cwr_a), .wdata(cur_wdata),
		.raddr(crd_a), .rdata(crd_e));

	// saturating add
	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(ACC_MAX)) return ACC_MAX;
		if (s < 65'(ACC_MIN)) return ACC_MIN;
		return s[63:0];
	endfunction

	function automatic logic zp_w(input logic signed [31:0] d);
		return d == 32'sd0;
	endfunction

	// controller: rows are swept in order; the delta check and the copy into
	// previous run per entry at the end of each sweep
	logic signed [32:0] diff_w;
	logic [32:0] adiff_w;
	logic [31:0] q_sat;
	logic signed [64:0] qs;
	logic [63:0] absnum;
	logic [64:0] trial;
	logic signed [63:0] num_w;
	logic phase_q; // 0: compare-copy step read, 1: act
	logic emit_last;

	assign diff_w = 33'(signed'(crd_e)) - 33'(signed'(prd));
	assign adiff_w = diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
	assign num_w = sadd(64'(b_q) <<< FRAC_BITS, (acc_q == ACC_MIN) ? ACC_MAX : -acc_q);
	assign absnum = num_w[63] ? 64'(-num_w) : 64'(num_w);
	assign trial = {drem_q, dnum_q[63]} - {33'd0, dden_q};
	assign qs = dneg_q ? -65'(dquo_q) : 65'(dquo_q);
	always_comb begin
		if (qs > 65'sd2147483647) q_sat = 32'h7FFF_FFFF;
		else if (qs < -65'sd2147483648) q_sat = 32'h8000_0000;
		else q_sat = qs[31:0];
	end

	always_comb begin
		state_d = state_q;
		prd_a = j_q[IW-1:0];
		crd_a = cnt_q;
		cur_we = 1'b0;
		prev_we = 1'b0;
		prev_wdata = crd_e;
		cwr_a = i_q;
		cur_wdata = zp_w(d_q) ? 32'd0 : q_sat;
		case (state_q)
			ST_LOAD:     if (in_acc && in_ch.last_element) state_d = ST_DOM_RD;
			ST_DOM_RD:   state_d = ST_DOM_ACC;
			ST_DOM_ACC: begin
				if (j_q == n_q && 32'(i_q) + 1 >= 32'(n_q)) state_d = ST_DOM_END;
				else state_d = ST_DOM_RD;
			end
			ST_DOM_END:  state_d = ST_SW_START;
			ST_SW_START: begin
				// clear both estimate arrays
				cur_we = 1'b1; cwr_a = cnt_q; cur_wdata = 32'd0;
				prev_we = 1'b1; prev_wdata = 32'd0;
				if (32'(cnt_q) + 1 >= 32'(n_q))
					state_d = (maxit_q == 16'd0) ? ST_EMIT : ST_ACC_RD;
			end
			ST_ACC_RD:   state_d = ST_ACC_MUL;
			ST_ACC_MUL:  state_d = ST_ACC_ADD;
			ST_ACC_ADD:  state_d = (j_q == n_q) ? ST_DIV : ST_ACC_RD;
			ST_DIV:      if (dstep_q == 7'(DIV_STEPS)) state_d = ST_DIV_END;
			ST_DIV_END: begin
				cur_we = 1'b1;
				if (32'(i_q) + 1 >= 32'(n_q)) state_d = ST_SW_END;
				else state_d = ST_ACC_RD;
			end
			ST_SW_END: begin
				// compare and copy current into previous, entry by entry, a read step then an act step
				prd_a = cnt_q;
				if (phase_q) begin
					prev_we = 1'b1;
					if (32'(cnt_q) + 1 >= 32'(n_q)) begin
						if (sweep_q == maxit_q || (stop_q && adiff_w < 33'(eps_q)))
							state_d = ST_EMIT;
						else state_d = ST_ACC_RD;
					end
				end
			end
			ST_EMIT: state_d = ST_EMIT_WAIT;
			ST_EMIT_WAIT: if (out_ch.valid && out_ch.ready && emit_last) state_d = ST_LOAD;
				else if (out_ch.valid && out_ch.ready) state_d = ST_EMIT;
			default: state_d = ST_LOAD;
		endcase
	end

	assign emit_last = (32'(cnt_q) + 1 >= 32'(n_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// datapath and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0; j_q <= '0; n_q <= NW'(1); cnt_q <= '0; sweep_q <= '0;
			conv_q <= 1'b0; dom_q <= 1'b0; zp_q <= 1'b0; stop_q <= 1'b0;
			phase_q <= 1'b0; dstep_q <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: if (in_acc && in_ch.last_element) begin
					n_q <= n_w; i_q <= '0; j_q <= '0; dom_q <= 1'b1; off_q <= '0;
					zp_q <= 1'b0; conv_q <= 1'b0; cnt_q <= '0; sweep_q <= '0;
				end
				ST_DOM_RD: ;
				ST_DOM_ACC: begin
					// crd holds a(i,j)
					if (j_q == NW'(i_q)) d_q <= crd;
					else if (j_q != n_q)
						off_q <= off_q + (crd[31] ? 64'(-65'(signed'(crd))) : 64'(crd));
					if (j_q == n_q) j_q <= '0;
					else j_q <= j_q + NW'(1);
				end
				ST_DOM_END: ;
				ST_SW_START: begin
					cnt_q <= (32'(cnt_q) + 1 >= 32'(n_q)) ? '0 : cnt_q + IW'(1);
					i_q <= '0; j_q <= '0; acc_q <= '0; stop_q <= 1'b1;
				end
				ST_ACC_RD: ;
				ST_ACC_MUL: begin
					// crd = a(i,j), prd = prev[j]
					if (j_q == NW'(i_q)) d_q <= crd;
					if (j_q == n_q) b_q <= crd;
					prod_s2 <= 64'(signed'(crd)) * 64'(signed'(prd));
				end
				ST_ACC_ADD: begin
					if (j_q != NW'(i_q) && j_q != n_q) acc_q <= sadd(acc_q, prod_s2);
					if (j_q == n_q) begin
						j_q <= '0;
						dnum_q <= absnum; drem_q <= '0; dquo_q <= '0; dstep_q <= '0;
						dden_q <= d_q[31] ? 32'(-33'(signed'(d_q))) : 32'(d_q);
						dneg_q <= num_w[63] ^ d_q[31];
					end else j_q <= j_q + NW'(1);
				end
				ST_DIV: if (dstep_q != 7'(DIV_STEPS)) begin
					// restoring division, one quotient bit a cycle
					dnum_q <= dnum_q << 1;
					if (!trial[64]) begin
						drem_q <= trial[63:0]; dquo_q <= {dquo_q[62:0], 1'b1};
					end else begin
						drem_q <= {drem_q[62:0], dnum_q[63]}; dquo_q <= {dquo_q[62:0], 1'b0};
					end
					dstep_q <= dstep_q + 7'd1;
				end
				ST_DIV_END: begin
					if (zp_w(d_q)) zp_q <= 1'b1;
					acc_q <= '0; j_q <= '0;
					if (32'(i_q) + 1 >= 32'(n_q)) begin
						i_q <= '0; sweep_q <= sweep_q + 16'd1; cnt_q <= '0; phase_q <= 1'b0;
						stop_q <= 1'b1;
					end else i_q <= i_q + IW'(1);
				end
				ST_SW_END: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						if (adiff_w >= 33'(eps_q)) stop_q <= 1'b0;
						if (32'(cnt_q) + 1 >= 32'(n_q)) begin
							cnt_q <= '0;
							if (stop_q && adiff_w < 33'(eps_q)) conv_q <= 1'b1;
						end else cnt_q <= cnt_q + IW'(1);
					end
				end
				ST_EMIT: out_ch.valid <= 1'b0;
				ST_EMIT_WAIT: begin
					if (!out_ch.valid) begin
						out_ch.valid <= 1'b1;
						out_ch.index <= 4'(cnt_q);
						out_ch.solution <= crd_e;
						out_ch.sweeps_done <= sweep_q;
						out_ch.converged <= conv_q;
						out_ch.diag_dominant <= dom_q;
						out_ch.zero_pivot <= zp_q;
						out_ch.last_result <= emit_last;
					end else if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						cnt_q <= emit_last ? '0 : cnt_q + IW'(1);
					end
				end
				default: ;
			endcase
			// dominance row end
			if (state_q == ST_DOM_ACC && j_q == n_q) begin
				if ((d_q[31] ? 64'(-65'(signed'(d_q))) : 64'(d_q)) < off_q) dom_q <= 1'b0;
				off_q <= '0;
				if (32'(i_q) + 1 < 32'(n_q)) i_q <= i_q + IW'(1);
			end
		end
	end

	// assertions
	a_ready_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == ST_LOAD) else $error("ready outside load");
	a_no_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> !out_ch.valid) else $error("result during load");
	a_sweep_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.sweeps_done <= maxit_q) else $error("sweep count over limit");
endmodule
`default_nettype wire
